// ===== hdl/pim_pkg.sv =====
// Shared types and fixed field widths for the priority inheritance mutex.
// No dependencies; used by the top level.
package pim_pkg;

   // Fixed widths of the transaction fields
   localparam int KIND_W     = 2;
   localparam int TASK_REQ_W = 3;
   localparam int PRIO_REQ_W = 4;
   localparam int STATUS_W   = 3;
   localparam int TASK_OUT_W = 4;
   localparam int PRIO_OUT_W = 4;

   typedef enum logic [KIND_W-1:0] {
      OP_ACQUIRE = 2'd0,
      OP_TRY     = 2'd1,
      OP_RELEASE = 2'd2,
      OP_WRITE   = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ACQUIRED  = 3'd0,
      ST_ALREADY   = 3'd1,
      ST_BLOCKED   = 3'd2,
      ST_FREED     = 3'd3,
      ST_HANDED    = 3'd4,
      ST_NOT_OWNER = 3'd5,
      ST_BUSY      = 3'd6,
      ST_WRITTEN   = 3'd7
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD_TASK,
      S_RD_OWNER,
      S_EXEC,
      S_SCAN,
      S_FINISH,
      S_DONE
   } state_type;

endpackage

// ===== hdl/priority_inheritance_mutex_top.sv =====
// Top level of the priority inheritance mutex: sequencer, lock state and scan.
// Depends on pim_pkg and pim_ram (task priority table).
//
// Usage:
//   The req_ channel carries one operation per transaction: acquire, try-acquire,
//   release or a task priority write. The rsp_ channel returns exactly one result
//   transaction per request with status, owner, woken task, owner and caller
//   priorities and a reschedule flag.
//   The sequencer reads the caller's and then the owner's priority, executes the
//   operation and loads the result. A release by the owner adds a scan of the
//   waiters' priorities through the single read port of the priority table RAM,
//   one entry per cycle, with one shared comparator picking the winner.
//   The sequencer takes a new request only once it is through with the last one;
//   req_ready is high only while the sequencer is idle.
//   The result sits in an output register; the next request is accepted while
//   it waits. If the receiver stalls, the following result is held back in the
//   sequencer until the output register frees up.
//   Reset: the lock is unowned, there are no waiters and every task priority
//   reads as zero (per-entry valid bits, no clearing pass).
module priority_inheritance_mutex_top #(
   parameter int TASKS     = 8,
   parameter int PRIO_BITS = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [pim_pkg::KIND_W-1:0]        req_kind,
   input  logic [pim_pkg::TASK_REQ_W-1:0]    req_task_req,
   input  logic [pim_pkg::PRIO_REQ_W-1:0]    req_priority_req,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [pim_pkg::STATUS_W-1:0]      rsp_status,
   output logic [pim_pkg::TASK_OUT_W-1:0]    rsp_owner,
   output logic [pim_pkg::TASK_OUT_W-1:0]    rsp_woken_task,
   output logic [pim_pkg::PRIO_OUT_W-1:0]    rsp_owner_priority,
   output logic [pim_pkg::PRIO_OUT_W-1:0]    rsp_caller_priority,
   output logic                              rsp_reschedule
);

   localparam int IW = $clog2(TASKS);
   localparam int TW = $clog2(TASKS + 1);
   localparam logic [TW-1:0] NO_TASK = TW'(TASKS);

   // Reduce the request's task index into range
   function automatic logic [IW-1:0] task_mod(input logic [pim_pkg::TASK_REQ_W-1:0] t);
      int v;
      v = int'(t);
      for (int k = 0; k < 4; k++) begin
         if (v >= TASKS) begin
            v = v - TASKS;
         end
      end
      return IW'(v);
   endfunction

   pim_pkg::state_type  state_ff, state_in;
   pim_pkg::op_type     kind_ff, kind_in;
   pim_pkg::status_type status_ff, status_in;

   logic [IW-1:0]        task_ff, task_in;
   logic [PRIO_BITS-1:0] prio_ff, prio_in;
   logic [TW-1:0]        owner_ff, owner_in;
   logic [PRIO_BITS-1:0] saved_ff, saved_in;
   logic [TASKS-1:0]     waiter_ff, waiter_in;
   logic [TASKS-1:0]     valid_ff, valid_in;
   logic                 rd_ok_ff, rd_ok_in;
   logic [PRIO_BITS-1:0] p_task_ff, p_task_in;
   logic [PRIO_BITS-1:0] p_own_ff, p_own_in;
   logic [TW-1:0]        best_ff, best_in;
   logic [PRIO_BITS-1:0] best_p_ff, best_p_in;
   logic [TW-1:0]        cnt_ff, cnt_in;
   logic [TW-1:0]        woken_ff, woken_in;
   logic                 resched_ff, resched_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   pim_pkg::status_type  rsp_status_ff, rsp_status_in;
   logic [pim_pkg::TASK_OUT_W-1:0] rsp_owner_ff, rsp_owner_in;
   logic [pim_pkg::TASK_OUT_W-1:0] rsp_woken_ff, rsp_woken_in;
   logic [pim_pkg::PRIO_OUT_W-1:0] rsp_own_prio_ff, rsp_own_prio_in;
   logic [pim_pkg::PRIO_OUT_W-1:0] rsp_call_prio_ff, rsp_call_prio_in;
   logic                           rsp_resched_ff, rsp_resched_in;

   // Table RAM control and shared comparator
   logic                 wr_en;
   logic [IW-1:0]        wr_addr;
   logic [PRIO_BITS-1:0] wr_data;
   logic [IW-1:0]        rd_addr;
   logic [PRIO_BITS-1:0] rd_data;
   logic [PRIO_BITS-1:0] rd_val;
   logic [PRIO_BITS-1:0] cmp_a, cmp_b;
   logic                 cmp_gt;

   logic                 owned;
   logic                 is_owner;
   logic [PRIO_BITS-1:0] p_own_cur;
   logic [TW-1:0]        cnt_prev;
   logic [IW-1:0]        scan_idx;
   logic                 out_free;

   pim_ram #(
      .WIDTH (PRIO_BITS),
      .DEPTH (TASKS)
   ) u_prio_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Entries never written read as zero
   assign rd_val    = rd_ok_ff ? rd_data : '0;
   assign owned     = (owner_ff != NO_TASK);
   assign is_owner  = (owner_ff == TW'(task_ff));
   assign p_own_cur = owned ? rd_val : '0;
   assign cnt_prev  = cnt_ff - TW'(1);
   assign scan_idx  = cnt_prev[IW-1:0];
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign cmp_gt    = (cmp_a > cmp_b);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pim_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = pim_pkg::S_RD_TASK;
            end
         end
         pim_pkg::S_RD_TASK:  state_in = pim_pkg::S_RD_OWNER;
         pim_pkg::S_RD_OWNER: state_in = pim_pkg::S_EXEC;
         pim_pkg::S_EXEC: begin
            if (kind_ff == pim_pkg::OP_RELEASE && is_owner) begin
               state_in = pim_pkg::S_SCAN;
            end else begin
               state_in = pim_pkg::S_DONE;
            end
         end
         pim_pkg::S_SCAN: begin
            if (cnt_ff == TW'(TASKS)) begin
               state_in = pim_pkg::S_FINISH;
            end
         end
         pim_pkg::S_FINISH: state_in = pim_pkg::S_DONE;
         pim_pkg::S_DONE: begin
            if (out_free) begin
               state_in = pim_pkg::S_IDLE;
            end
         end
         default: state_in = pim_pkg::S_IDLE;
      endcase
   end

   // Sequencer outputs: handshake, RAM ports, comparator operands
   always_comb begin
      req_ready = 1'b0;
      rd_addr   = '0;
      wr_en     = 1'b0;
      wr_addr   = task_ff;
      wr_data   = prio_ff;
      cmp_a     = p_task_ff;
      cmp_b     = p_own_cur;
      case (state_ff)
         pim_pkg::S_IDLE: req_ready = 1'b1;
         pim_pkg::S_RD_TASK: rd_addr = task_ff;
         pim_pkg::S_RD_OWNER: begin
            if (owned) begin
               rd_addr = owner_ff[IW-1:0];
            end
         end
         pim_pkg::S_EXEC: begin
            case (kind_ff)
               pim_pkg::OP_WRITE: wr_en = 1'b1;
               pim_pkg::OP_ACQUIRE: begin
                  // Boost the owner to a higher-ranked blocked caller
                  if (owned && !is_owner && cmp_gt) begin
                     wr_en   = 1'b1;
                     wr_addr = owner_ff[IW-1:0];
                     wr_data = p_task_ff;
                  end
               end
               pim_pkg::OP_RELEASE: begin
                  // Restore the releasing owner's priority
                  if (is_owner) begin
                     wr_en   = 1'b1;
                     wr_data = saved_ff;
                  end
               end
               default: wr_en = 1'b0;
            endcase
         end
         pim_pkg::S_SCAN: begin
            if (cnt_ff < TW'(TASKS)) begin
               rd_addr = cnt_ff[IW-1:0];
            end
            cmp_a = rd_val;
            cmp_b = best_p_ff;
         end
         pim_pkg::S_FINISH: begin
            cmp_a = best_p_ff;
            cmp_b = p_task_ff;
         end
         default: req_ready = 1'b0;
      endcase
   end

   // Lock state and scratch datapath
   always_comb begin
      kind_in    = kind_ff;
      task_in    = task_ff;
      prio_in    = prio_ff;
      owner_in   = owner_ff;
      saved_in   = saved_ff;
      waiter_in  = waiter_ff;
      p_task_in  = p_task_ff;
      p_own_in   = p_own_ff;
      best_in    = best_ff;
      best_p_in  = best_p_ff;
      cnt_in     = cnt_ff;
      woken_in   = woken_ff;
      resched_in = resched_ff;
      status_in  = status_ff;
      valid_in   = valid_ff | (wr_en ? (TASKS'(1) << wr_addr) : '0);
      rd_ok_in   = valid_ff[rd_addr];

      case (state_ff)
         pim_pkg::S_IDLE: begin
            if (req_valid) begin
               kind_in = pim_pkg::op_type'(req_kind);
               task_in = task_mod(req_task_req);
               prio_in = PRIO_BITS'(req_priority_req);
            end
         end
         pim_pkg::S_RD_OWNER: p_task_in = rd_val;
         pim_pkg::S_EXEC: begin
            p_own_in   = p_own_cur;
            woken_in   = NO_TASK;
            resched_in = 1'b0;
            cnt_in     = '0;
            best_in    = NO_TASK;
            best_p_in  = '0;
            case (kind_ff)
               pim_pkg::OP_ACQUIRE, pim_pkg::OP_TRY: begin
                  if (!owned) begin
                     owner_in  = TW'(task_ff);
                     saved_in  = p_task_ff;
                     p_own_in  = p_task_ff;
                     status_in = pim_pkg::ST_ACQUIRED;
                  end else if (kind_ff == pim_pkg::OP_TRY) begin
                     status_in = pim_pkg::ST_BUSY;
                  end else if (is_owner) begin
                     status_in = pim_pkg::ST_ALREADY;
                  end else begin
                     if (cmp_gt) begin
                        p_own_in = p_task_ff;
                     end
                     waiter_in = waiter_ff | (TASKS'(1) << task_ff);
                     status_in = pim_pkg::ST_BLOCKED;
                  end
               end
               pim_pkg::OP_RELEASE: begin
                  if (!is_owner) begin
                     status_in = pim_pkg::ST_NOT_OWNER;
                  end else begin
                     p_task_in = saved_ff;
                  end
               end
               default: begin
                  p_task_in = prio_ff;
                  if (is_owner) begin
                     p_own_in = prio_ff;
                  end
                  status_in = pim_pkg::ST_WRITTEN;
               end
            endcase
         end
         pim_pkg::S_SCAN: begin
            // Keep the highest waiter, the lowest index winning ties
            if (cnt_ff != '0) begin
               if (waiter_ff[scan_idx] && (best_ff == NO_TASK || cmp_gt)) begin
                  best_in   = TW'(scan_idx);
                  best_p_in = rd_val;
               end
            end
            if (cnt_ff < TW'(TASKS)) begin
               cnt_in = cnt_ff + TW'(1);
            end
         end
         pim_pkg::S_FINISH: begin
            if (best_ff == NO_TASK) begin
               owner_in  = NO_TASK;
               p_own_in  = '0;
               status_in = pim_pkg::ST_FREED;
            end else begin
               // The winner ranks at least as high as all remaining waiters: no boost needed
               waiter_in  = waiter_ff & ~(TASKS'(1) << best_ff[IW-1:0]);
               owner_in   = best_ff;
               saved_in   = best_p_ff;
               p_own_in   = best_p_ff;
               woken_in   = best_ff;
               resched_in = cmp_gt;
               status_in  = pim_pkg::ST_HANDED;
            end
         end
         default: cnt_in = cnt_ff;
      endcase
   end

   // Output register: drop on acceptance, load from the sequencer when free
   always_comb begin
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_status_in    = rsp_status_ff;
      rsp_owner_in     = rsp_owner_ff;
      rsp_woken_in     = rsp_woken_ff;
      rsp_own_prio_in  = rsp_own_prio_ff;
      rsp_call_prio_in = rsp_call_prio_ff;
      rsp_resched_in   = rsp_resched_ff;
      if (state_ff == pim_pkg::S_DONE && out_free) begin
         rsp_valid_in     = 1'b1;
         rsp_status_in    = status_ff;
         rsp_owner_in     = pim_pkg::TASK_OUT_W'(owner_ff);
         rsp_woken_in     = pim_pkg::TASK_OUT_W'(woken_ff);
         rsp_own_prio_in  = pim_pkg::PRIO_OUT_W'(p_own_ff);
         rsp_call_prio_in = pim_pkg::PRIO_OUT_W'(p_task_ff);
         rsp_resched_in   = resched_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pim_pkg::S_IDLE;
         owner_ff     <= NO_TASK;
         saved_ff     <= '0;
         waiter_ff    <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         owner_ff     <= owner_in;
         saved_ff     <= saved_in;
         waiter_ff    <= waiter_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and scratch registers
   always_ff @(posedge clock) begin
      kind_ff          <= kind_in;
      task_ff          <= task_in;
      prio_ff          <= prio_in;
      rd_ok_ff         <= rd_ok_in;
      p_task_ff        <= p_task_in;
      p_own_ff         <= p_own_in;
      best_ff          <= best_in;
      best_p_ff        <= best_p_in;
      cnt_ff           <= cnt_in;
      woken_ff         <= woken_in;
      resched_ff       <= resched_in;
      status_ff        <= status_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_owner_ff     <= rsp_owner_in;
      rsp_woken_ff     <= rsp_woken_in;
      rsp_own_prio_ff  <= rsp_own_prio_in;
      rsp_call_prio_ff <= rsp_call_prio_in;
      rsp_resched_ff   <= rsp_resched_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_owner           = rsp_owner_ff;
   assign rsp_woken_task      = rsp_woken_ff;
   assign rsp_owner_priority  = rsp_own_prio_ff;
   assign rsp_caller_priority = rsp_call_prio_ff;
   assign rsp_reschedule      = rsp_resched_ff;

   // The owner is never queued as a waiter
   a_owner_not_waiting: assert property (@(posedge clock) disable iff (reset)
      owned |-> !waiter_ff[owner_ff[IW-1:0]])
      else $error("owner found in waiter map");

   // No waiters while the lock is free
   a_free_no_waiters: assert property (@(posedge clock) disable iff (reset)
      !owned |-> (waiter_ff == '0))
      else $error("waiters pending on a free lock");

   // A handover result names the new owner as the woken task
   a_handover_woken: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == pim_pkg::ST_HANDED) |->
         (rsp_woken_ff == rsp_owner_ff))
      else $error("woken task differs from new owner");

   // Only a handover wakes a task or asks for a reschedule
   a_wake_only_on_handover: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != pim_pkg::ST_HANDED) |->
         (rsp_woken_ff == pim_pkg::TASK_OUT_W'(NO_TASK) && !rsp_resched_ff))
      else $error("wake or reschedule outside a handover");

endmodule

// ===== hdl/pim_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pim_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, and register the read (old data on a same-address write)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
